@@ hw/rtl/tchf_pkg.sv @@
// Package for the TLS client hello fingerprint block.
// Holds parse phase codes, constants, channel item types and datapath command/status types.
// No dependencies.
`timescale 1ns / 1ps
package tchf_pkg;

    localparam int LENGTH_BITS_DEF = 16;

    localparam logic [3:0] PH_HEADER  = 4'd0;
    localparam logic [3:0] PH_SID     = 4'd1;
    localparam logic [3:0] PH_CSLEN   = 4'd2;
    localparam logic [3:0] PH_SUITES  = 4'd3;
    localparam logic [3:0] PH_COMP    = 4'd4;
    localparam logic [3:0] PH_EXTLEN  = 4'd5;
    localparam logic [3:0] PH_EXT     = 4'd6;
    localparam logic [3:0] PH_EXTDONE = 4'd7;

    localparam logic [7:0]  REC_HANDSHAKE = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
    localparam logic [15:0] GREASE_MASK = 16'h0F0F;
    localparam logic [15:0] GREASE_VAL  = 16'h0A0A;
    localparam logic [31:0] SEED_FIRST  = 32'd5381;
    localparam logic [31:0] SEED_SECOND = 32'h9E3779B9;
    localparam logic [15:0] MIN_LEN     = 16'd43;

    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_DASH  = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;

    // input item: one payload byte
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] frame_len;
        logic        first_byte;
    } tchf_in_t;

    // result item: one fingerprint
    typedef struct packed {
        logic        fingerprint_valid;
        logic [15:0] client_version;
        logic [14:0] suite_count;
        logic [13:0] extension_count;
        logic [31:0] hash_first;
        logic [31:0] hash_second;
        logic [31:0] hash_mixed_xor;
        logic [31:0] hash_mixed_sum;
    } tchf_out_t;

    // commands from controller to datapath
    typedef struct packed {
        logic        clear;     // reset hash and digit engine
        logic        start_num; // load number (with optional prefix/suffix)
        logic [15:0] num;
        logic        pre_dash;
        logic        post_comma;
        logic        comma_only;
    } tchf_cmd_t;

    typedef struct packed {
        logic        busy;
        logic [31:0] h1;
        logic [31:0] h2;
    } tchf_sts_t;

endpackage

@@ hw/rtl/tchf_stream_if.sv @@
// Valid/ready channel interface carrying a generic payload.
// No dependencies.
`timescale 1ns / 1ps
interface tchf_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/tchf_hash_dp.sv @@
// Datapath: decimal digit extraction and the two djb2-xor hashes.
// One character per cycle. Depends on tchf_pkg.
`timescale 1ns / 1ps
module tchf_hash_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  tchf_pkg::tchf_cmd_t cmd,
    output tchf_pkg::tchf_sts_t sts
);
    localparam logic [7:0] CHZ = 8'd0;

    logic [31:0] h1_reg, h1_next, h2_reg, h2_next;
    logic [15:0] val_reg, val_next;
    logic [15:0] pow_reg, pow_next;
    logic        dash_reg, dash_next, comma_reg, comma_next;
    logic        active_reg, active_next;
    logic [7:0]  ch;
    logic        fire;
    logic [3:0]  dig;
    logic [19:0] rem;
    logic [19:0] pw;

    function automatic logic [15:0] top_pow(input logic [15:0] v);
        if (v >= 16'd10000)     top_pow = 16'd10000;
        else if (v >= 16'd1000) top_pow = 16'd1000;
        else if (v >= 16'd100)  top_pow = 16'd100;
        else if (v >= 16'd10)   top_pow = 16'd10;
        else                    top_pow = 16'd1;
    endfunction

    always_comb
    begin
        dig = 4'd0;
        pw = {4'd0, pow_reg};
        rem = {4'd0, val_reg};
        if (rem >= (pw << 3)) begin dig = dig + 4'd8; rem = rem - (pw << 3); end
        if (rem >= (pw << 2)) begin dig = dig + 4'd4; rem = rem - (pw << 2); end
        if (rem >= (pw << 1)) begin dig = dig + 4'd2; rem = rem - (pw << 1); end
        if (rem >= pw)        begin dig = dig + 4'd1; rem = rem - pw; end
    end

    always_comb
    begin
        h1_next = h1_reg;
        h2_next = h2_reg;
        val_next = val_reg;
        pow_next = pow_reg;
        dash_next = dash_reg;
        comma_next = comma_reg;
        active_next = active_reg;
        ch = CHZ;
        fire = 1'b0;
        if (active_reg) begin
            fire = 1'b1;
            if (dash_reg) begin
                ch = tchf_pkg::CH_DASH;
                dash_next = 1'b0;
            end else if (pow_reg != 16'd0) begin
                ch = tchf_pkg::CH_ZERO + {4'd0, dig};
                val_next = rem[15:0];
                // pow / 10 via small table
                case (pow_reg)
                    16'd10000: pow_next = 16'd1000;
                    16'd1000:  pow_next = 16'd100;
                    16'd100:   pow_next = 16'd10;
                    16'd10:    pow_next = 16'd1;
                    default:   pow_next = 16'd0;
                endcase
                if (pow_reg == 16'd1 && !comma_reg) active_next = 1'b0;
            end else begin
                ch = tchf_pkg::CH_COMMA;
                comma_next = 1'b0;
                active_next = 1'b0;
            end
        end
        if (fire) begin
            h1_next = (h1_reg * 32'd33) ^ {24'd0, ch};
            h2_next = (h2_reg * 32'd33) ^ {24'd0, ch};
        end
        if (cmd.start_num) begin
            active_next = 1'b1;
            dash_next = cmd.pre_dash;
            comma_next = cmd.post_comma | cmd.comma_only;
            val_next = cmd.num;
            pow_next = cmd.comma_only ? 16'd0 : top_pow(cmd.num);
        end
        if (cmd.clear) begin
            h1_next = tchf_pkg::SEED_FIRST;
            h2_next = tchf_pkg::SEED_SECOND;
            active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            h1_reg <= tchf_pkg::SEED_FIRST;
            h2_reg <= tchf_pkg::SEED_SECOND;
            active_reg <= 1'b0;
            dash_reg <= 1'b0;
            comma_reg <= 1'b0;
        end else begin
            h1_reg <= h1_next;
            h2_reg <= h2_next;
            active_reg <= active_next;
            dash_reg <= dash_next;
            comma_reg <= comma_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        pow_reg <= pow_next;
    end

    assign sts.busy = active_reg;
    assign sts.h1 = h1_reg;
    assign sts.h2 = h2_reg;
endmodule

@@ hw/rtl/tchf_parse_ctrl.sv @@
// Controller: ClientHello parse state machine and result staging.
// Issues number/character commands to the hash datapath. Depends on tchf_pkg.
`timescale 1ns / 1ps
module tchf_parse_ctrl #(
    parameter int LENGTH_BITS = tchf_pkg::LENGTH_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic [15:0]         frame_len,
    input  logic                first_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [173:0]        out_data,
    output tchf_pkg::tchf_cmd_t cmd,
    input  tchf_pkg::tchf_sts_t sts
);
    localparam int LB = LENGTH_BITS;

    logic [LB-1:0] pos_reg, pos_next;
    logic [3:0]    ph_reg, ph_next;
    logic [7:0]    acc_reg, acc_next;
    logic [17:0]   send_reg, send_next;
    logic [16:0]   eend_reg, eend_next;
    logic [17:0]   skip_reg, skip_next;
    logic [14:0]   sc_reg, sc_next;
    logic [13:0]   ec_reg, ec_next;
    logic          empty_reg, empty_next;
    logic          fail_reg, fail_next;
    logic [15:0]   ver_reg, ver_next;
    logic          fin_reg, fin_next;   // result pending after hash drains
    logic          fval_reg, fval_next;
    logic          ov_reg;
    logic [173:0]  od_reg;

    logic          take;
    logic [17:0]   p, len;
    logic [15:0]   v;
    logic          nongrease;
    logic [17:0]   d;

    assign in_ready = !sts.busy && !fin_reg;
    assign take = in_valid && in_ready;

    always_comb
    begin
        pos_next = pos_reg; ph_next = ph_reg; acc_next = acc_reg;
        send_next = send_reg; eend_next = eend_reg; skip_next = skip_reg;
        sc_next = sc_reg; ec_next = ec_reg; empty_next = empty_reg;
        fail_next = fail_reg; ver_next = ver_reg; fin_next = fin_reg;
        fval_next = fval_reg;
        cmd = '0;
        p = 18'd0; len = 18'd0; v = 16'd0; d = 18'd0; nongrease = 1'b0;
        if (take) begin
            if (first_byte) begin
                pos_next = '0; ph_next = tchf_pkg::PH_HEADER; acc_next = '0;
                send_next = '0; eend_next = '0; skip_next = '0;
                sc_next = '0; ec_next = '0; empty_next = 1'b1;
                fail_next = 1'b0; ver_next = '0;
                cmd.clear = 1'b1;
                p = 18'd0;
            end else begin
                p = {{(18-LB){1'b0}}, pos_reg};
            end
            len = {{(18-LB){1'b0}}, frame_len[LB-1:0]};
            v = {acc_next, data_byte};
            nongrease = (v & tchf_pkg::GREASE_MASK) != tchf_pkg::GREASE_VAL;
            if (!fail_next) begin
                case (ph_next)
                    tchf_pkg::PH_HEADER:
                    begin
                        if (p == 18'd0 && data_byte != tchf_pkg::REC_HANDSHAKE)
                            fail_next = 1'b1;
                        else if (p == 18'd5 && data_byte != tchf_pkg::HS_CLIENT_HELLO)
                            fail_next = 1'b1;
                        else if (p == 18'd9)
                            acc_next = data_byte;
                        else if (p == 18'd10) begin
                            ver_next = v;
                            cmd.start_num = 1'b1; cmd.num = v; cmd.post_comma = 1'b1;
                        end else if (p == 18'd43) begin
                            skip_next = 18'd44 + {10'd0, data_byte};
                            if (skip_next + 18'd2 > len) fail_next = 1'b1;
                            ph_next = tchf_pkg::PH_SID;
                        end
                    end
                    tchf_pkg::PH_SID:
                    begin
                        if (p == skip_next) begin
                            acc_next = data_byte; ph_next = tchf_pkg::PH_CSLEN;
                        end
                    end
                    tchf_pkg::PH_CSLEN:
                    begin
                        send_next = p + 18'd1 + {2'd0, v};
                        if (send_next > len) fail_next = 1'b1;
                        skip_next = p + 18'd1;
                        empty_next = 1'b1;
                        ph_next = tchf_pkg::PH_SUITES;
                    end
                    tchf_pkg::PH_SUITES:
                    begin
                        if (p >= send_next) begin
                            if (p >= len) fail_next = 1'b1;
                            else begin
                                cmd.start_num = 1'b1; cmd.comma_only = 1'b1;
                                empty_next = 1'b1;
                                skip_next = p + 18'd1 + {10'd0, data_byte};
                                if (skip_next + 18'd2 > len) fail_next = 1'b1;
                                ph_next = tchf_pkg::PH_COMP;
                            end
                        end else if (p == skip_next) begin
                            if (p + 18'd2 <= send_next) acc_next = data_byte;
                        end else if (p == skip_next + 18'd1) begin
                            skip_next = p + 18'd1;
                            if (nongrease) begin
                                sc_next = sc_next + 15'd1;
                                cmd.start_num = 1'b1; cmd.num = v;
                                cmd.pre_dash = !empty_next;
                                empty_next = 1'b0;
                            end
                        end
                    end
                    tchf_pkg::PH_COMP:
                    begin
                        if (p == skip_next) begin
                            acc_next = data_byte; ph_next = tchf_pkg::PH_EXTLEN;
                        end
                    end
                    tchf_pkg::PH_EXTLEN:
                    begin
                        d = p + 18'd1 + {2'd0, v};
                        eend_next = (d > len) ? len[16:0] : d[16:0];
                        skip_next = p + 18'd1;
                        ph_next = tchf_pkg::PH_EXT;
                    end
                    tchf_pkg::PH_EXT:
                    begin
                        if (p >= skip_next) begin
                            d = p - skip_next;
                            if (d == 18'd0) begin
                                if (skip_next + 18'd4 > {1'b0, eend_next})
                                    ph_next = tchf_pkg::PH_EXTDONE;
                                else acc_next = data_byte;
                            end else if (d == 18'd1) begin
                                if (nongrease) begin
                                    ec_next = ec_next + 14'd1;
                                    cmd.start_num = 1'b1; cmd.num = v;
                                    cmd.pre_dash = !empty_next;
                                    empty_next = 1'b0;
                                end
                            end else if (d == 18'd2) begin
                                acc_next = data_byte;
                            end else if (d == 18'd3) begin
                                skip_next = p + 18'd1 + {2'd0, v};
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (p + 18'd1 < len) begin
                pos_next = LB'(p + 18'd1);
            end else begin
                fin_next = 1'b1;
                fval_next = !fail_next && (len >= {2'd0, tchf_pkg::MIN_LEN}) &&
                            (ph_next == tchf_pkg::PH_EXT || ph_next == tchf_pkg::PH_EXTDONE);
            end
        end
        if (fin_reg && !sts.busy && (!ov_reg || out_ready)) begin
            fin_next = 1'b0;
            pos_next = '0; ph_next = tchf_pkg::PH_HEADER; acc_next = '0;
            send_next = '0; eend_next = '0; skip_next = '0;
            sc_next = '0; ec_next = '0; empty_next = 1'b1;
            fail_next = 1'b0; ver_next = '0;
            cmd.clear = 1'b1;
        end
    end

    logic [31:0] h1m, h2m;
    assign h1m = fval_reg ? sts.h1 : 32'd0;
    assign h2m = fval_reg ? sts.h2 : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= '0; ph_reg <= tchf_pkg::PH_HEADER; acc_reg <= '0;
            send_reg <= '0; eend_reg <= '0; skip_reg <= '0;
            sc_reg <= '0; ec_reg <= '0; empty_reg <= 1'b1;
            fail_reg <= 1'b0; ver_reg <= '0; fin_reg <= 1'b0;
            fval_reg <= 1'b0; ov_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next; ph_reg <= ph_next; acc_reg <= acc_next;
            send_reg <= send_next; eend_reg <= eend_next; skip_reg <= skip_next;
            sc_reg <= sc_next; ec_reg <= ec_next; empty_reg <= empty_next;
            fail_reg <= fail_next; ver_reg <= ver_next; fin_reg <= fin_next;
            fval_reg <= fval_next;
            if (fin_reg && !sts.busy && (!ov_reg || out_ready))
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_reg && !sts.busy && (!ov_reg || out_ready))
            od_reg <= {fval_reg,
                       fval_reg ? ver_reg : 16'd0,
                       fval_reg ? sc_reg : 15'd0,
                       fval_reg ? ec_reg : 14'd0,
                       h1m, h2m, h1m ^ h2m, h1m + h2m};
    end

    assign out_valid = ov_reg;
    assign out_data = od_reg;
endmodule

@@ hw/rtl/tls_client_hello_fingerprint.sv @@
// Top level of the TLS client hello fingerprint block.
// Instantiates tchf_parse_ctrl and tchf_hash_dp; uses tchf_pkg, tchf_stream_if.
//
// Usage:
//   Input channel in_ch carries one payload byte per item with frame_len
//   and first_byte. Output channel out_ch carries one fingerprint result per
//   payload, given after its last byte.
//   Rate: one byte per cycle while the hash datapath is idle and no result
//   is pending. A byte that completes a suite, extension or version adds up
//   to 6 characters to the text, hashed one per cycle by the single-character
//   hash datapath; no byte is taken until it is done. The result appears
//   once the hash engine drains; the next byte is taken from that cycle on.
//   Reset clears the parse and the hashes; no result is pending.
//   When the receiver stalls, the result holds in the output register and
//   the block keeps taking bytes of the next payload until that payload
//   ends; it then waits for the register to empty.
`timescale 1ns / 1ps
module tls_client_hello_fingerprint #(
    parameter int LENGTH_BITS = tchf_pkg::LENGTH_BITS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    tchf_stream_if.sink   in_ch,
    tchf_stream_if.source out_ch
);
    tchf_pkg::tchf_cmd_t cmd;
    tchf_pkg::tchf_sts_t sts;
    logic [173:0] od;

    tchf_parse_ctrl #(.LENGTH_BITS(LENGTH_BITS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .data_byte(in_ch.payload.data_byte),
        .frame_len(in_ch.payload.frame_len),
        .first_byte(in_ch.payload.first_byte),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_data(od), .cmd(cmd), .sts(sts)
    );

    tchf_hash_dp u_dp (.clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts));

    assign out_ch.payload = od;
endmodule
